[src/operand_addressing_mode_unit_top_macros.svh]
// Assertion macros shared by the operand addressing unit
`ifndef OPERAND_ADDRESSING_MODE_UNIT_TOP_MACROS_SVH
`define OPERAND_ADDRESSING_MODE_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define OAMU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define OAMU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/oamu_pkg.sv]
// Types, codes and sizes for the operand addressing unit
package oamu_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int WORD_AW   = MEM_AW - 1;
  localparam int REG_COUNT = 8;
  localparam int REG_AW    = $clog2(REG_COUNT);

  // item kinds
  localparam logic [1:0] KIND_RESOLVE  = 2'd0;
  localparam logic [1:0] KIND_LOAD_MEM = 2'd1;
  localparam logic [1:0] KIND_LOAD_REG = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_MODE = 2'd1;
  localparam logic [1:0] ST_LOAD     = 2'd2;

  // addressing modes
  localparam logic [2:0] MODE_DIRECT      = 3'd0;
  localparam logic [2:0] MODE_DEF         = 3'd1;
  localparam logic [2:0] MODE_AUTOINC     = 3'd2;
  localparam logic [2:0] MODE_AUTOINC_DEF = 3'd3;
  localparam logic [2:0] MODE_AUTODEC     = 3'd4;

  // stack pointer and PC always step by a word
  localparam logic [REG_AW-1:0] REG_SP = REG_AW'(6);
  localparam logic [15:0] STEP_BYTE = 16'd1;
  localparam logic [15:0] STEP_WORD = 16'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  specifier;
    logic        byte_op;
    logic [15:0] load_address;
    logic [2:0]  reg_index;
    logic [15:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] operand_address;
    logic [15:0] operand_value;
    logic [2:0]  mode_used;
    logic [1:0]  status;
  } out_item_t;

  // request to the byte memory: one byte write or one word-row read
  typedef struct packed {
    logic               wr_en;
    logic [MEM_AW-1:0]  wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [WORD_AW-1:0] rd_row;
  } mem_req_t;

endpackage

[src/operand_addressing_mode_unit_top.sv]
// Top level of the operand addressing unit: register file, sequencer, result register
//
//  Channel | Ports                          | Direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_stall, in_item    | in
//  result  | out_valid, out_stall, out_item | out
//
// One item at a time. Loads, mode 0, modes 5-7 and the ignored kind finish in S_IDLE;
// modes 1, 2, 4 pass through S_DATA and mode 3 through S_PTR and S_DATA, set by the
// dependent reads of the banked memory (registered read). Reset clears the register file and
// the control state; memory content is undefined until loaded. A result waiting in
// the output register does not block the next item; a result that finishes while
// that register is held by out_stall waits in S_OUT and stalls the input until
// out_stall drops.
`include "operand_addressing_mode_unit_top_macros.svh"

module operand_addressing_mode_unit_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  oamu_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output oamu_pkg::out_item_t out_item
);

  typedef enum logic [1:0] {S_IDLE, S_PTR, S_DATA, S_OUT} state_t;

  state_t                                 state_r, state_nxt;
  logic [oamu_pkg::REG_COUNT-1:0][15:0]   regs_r;
  logic                                   reg_we;
  logic [oamu_pkg::REG_AW-1:0]            reg_wa;
  logic [15:0]                            reg_wd;
  logic                                   out_valid_r, out_valid_nxt;
  oamu_pkg::out_item_t                    out_r, out_nxt;
  oamu_pkg::out_item_t                    res_r, res_nxt;
  logic [15:0]                            adr_r, adr_nxt;
  logic [2:0]                             mode_r, mode_nxt;
  logic                                   bmode_r, bmode_nxt;
  logic                                   bsel_r, bsel_nxt;
  oamu_pkg::mem_req_t                     mreq;
  logic [7:0]                             rd_lo;
  logic [7:0]                             rd_hi;
  logic                                   acc;
  logic                                   out_free;
  logic [oamu_pkg::REG_AW-1:0]            rsel;
  logic [2:0]                             mode;
  logic [15:0]                            rv;
  logic [15:0]                            step;
  logic [15:0]                            ptr;
  logic [15:0]                            rd_val;
  logic                                   emit;
  oamu_pkg::out_item_t                    emit_item;

  oamu_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rd_lo (rd_lo),
    .rd_hi (rd_hi)
  );

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // decode of the incoming specifier
  assign rsel = in_item.specifier[2:0];
  assign mode = in_item.specifier[5:3];
  assign rv   = regs_r[rsel];
  assign step = (in_item.byte_op && (rsel < oamu_pkg::REG_SP)) ?
                oamu_pkg::STEP_BYTE : oamu_pkg::STEP_WORD;

  // memory read data as pointer and as sized operand
  assign ptr    = {rd_hi, rd_lo};
  assign rd_val = bmode_r ? {8'd0, (bsel_r ? rd_hi : rd_lo)} : ptr;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    reg_we    = 1'b0;
    reg_wa    = rsel;
    reg_wd    = in_item.load_data;
    res_nxt   = res_r;
    adr_nxt   = adr_r;
    mode_nxt  = mode_r;
    bmode_nxt = bmode_r;
    bsel_nxt  = bsel_r;
    mreq      = '0;
    emit      = 1'b0;
    emit_item = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          mode_nxt  = mode;
          bmode_nxt = in_item.byte_op;
          unique case (in_item.kind)
            oamu_pkg::KIND_LOAD_MEM: begin
              mreq.wr_en   = 1'b1;
              mreq.wr_addr = in_item.load_address[oamu_pkg::MEM_AW-1:0];
              mreq.wr_data = in_item.load_data[7:0];
              emit         = 1'b1;
              emit_item    = '{16'd0, 16'd0, oamu_pkg::MODE_DIRECT, oamu_pkg::ST_LOAD};
            end
            oamu_pkg::KIND_LOAD_REG: begin
              reg_we    = 1'b1;
              reg_wa    = in_item.reg_index;
              reg_wd    = in_item.load_data;
              emit      = 1'b1;
              emit_item = '{16'd0, 16'd0, oamu_pkg::MODE_DIRECT, oamu_pkg::ST_LOAD};
            end
            oamu_pkg::KIND_RESOLVE: begin
              unique case (mode)
                oamu_pkg::MODE_DIRECT: begin
                  emit      = 1'b1;
                  emit_item = '{16'(rsel),
                                (in_item.byte_op ? {8'd0, rv[7:0]} : rv),
                                mode, oamu_pkg::ST_OK};
                end
                oamu_pkg::MODE_DEF: begin
                  mreq.rd_en  = 1'b1;
                  mreq.rd_row = rv[oamu_pkg::MEM_AW-1:1];
                  adr_nxt     = rv;
                  bsel_nxt    = rv[0];
                  state_nxt   = S_DATA;
                end
                oamu_pkg::MODE_AUTOINC: begin
                  mreq.rd_en  = 1'b1;
                  mreq.rd_row = rv[oamu_pkg::MEM_AW-1:1];
                  adr_nxt     = rv;
                  bsel_nxt    = rv[0];
                  reg_we      = 1'b1;
                  reg_wd      = rv + step;
                  state_nxt   = S_DATA;
                end
                oamu_pkg::MODE_AUTOINC_DEF: begin
                  // pointer is always read as a word
                  mreq.rd_en  = 1'b1;
                  mreq.rd_row = rv[oamu_pkg::MEM_AW-1:1];
                  reg_we      = 1'b1;
                  reg_wd      = rv + oamu_pkg::STEP_WORD;
                  state_nxt   = S_PTR;
                end
                oamu_pkg::MODE_AUTODEC: begin
                  mreq.rd_en  = 1'b1;
                  reg_we      = 1'b1;
                  reg_wd      = rv - step;
                  mreq.rd_row = reg_wd[oamu_pkg::MEM_AW-1:1];
                  adr_nxt     = reg_wd;
                  bsel_nxt    = reg_wd[0];
                  state_nxt   = S_DATA;
                end
                default: begin
                  emit      = 1'b1;
                  emit_item = '{16'd0, 16'd0, mode, oamu_pkg::ST_BAD_MODE};
                end
              endcase
            end
            default: begin
              // unknown kind: dropped without a result
            end
          endcase
        end
      end
      S_PTR: begin
        mreq.rd_en  = 1'b1;
        mreq.rd_row = ptr[oamu_pkg::MEM_AW-1:1];
        adr_nxt     = ptr;
        bsel_nxt    = ptr[0];
        state_nxt   = S_DATA;
      end
      S_DATA: begin
        emit      = 1'b1;
        emit_item = '{adr_r, rd_val, mode_r, oamu_pkg::ST_OK};
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a finished result goes straight out when the result register is free
    if (emit) begin
      if (out_free) begin
        state_nxt = S_IDLE;
      end else begin
        res_nxt   = emit_item;
        state_nxt = S_OUT;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit && out_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = emit_item;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r   <= out_nxt;
    res_r   <= res_nxt;
    adr_r   <= adr_nxt;
    mode_r  <= mode_nxt;
    bmode_r <= bmode_nxt;
    bsel_r  <= bsel_nxt;
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (reg_we) begin
      regs_r[reg_wa] <= reg_wd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  `OAMU_ASSERT_NEXT(a_bad_mode_keeps_regs, acc && (in_item.kind == oamu_pkg::KIND_RESOLVE) && (in_item.specifier[5:3] > oamu_pkg::MODE_AUTODEC), $stable(regs_r), "register file changed on an unimplemented mode")
  `OAMU_ASSERT_SAME(a_read_only_when_issuing, mreq.rd_en, (state_r == S_IDLE) || (state_r == S_PTR), "memory read issued outside the issue states")
  `OAMU_ASSERT_SAME(a_data_follows_read, state_r == S_DATA, $past(mreq.rd_en), "data state entered without a pending read")
  `OAMU_ASSERT_SAME(a_load_result_zero, out_valid_r && (out_r.status == oamu_pkg::ST_LOAD), (out_r.operand_address == 16'd0) && (out_r.operand_value == 16'd0) && (out_r.mode_used == oamu_pkg::MODE_DIRECT), "load result carries nonzero fields")

endmodule

[src/oamu_mem.sv]
// Byte memory split into even and odd banks, registered read
module oamu_mem (
  input  logic                clk,
  input  oamu_pkg::mem_req_t  req,
  output logic [7:0]          rd_lo,
  output logic [7:0]          rd_hi
);

  logic [7:0] even_mem [oamu_pkg::MEM_BYTES/2];
  logic [7:0] odd_mem  [oamu_pkg::MEM_BYTES/2];
  logic [7:0] rd_lo_r;
  logic [7:0] rd_hi_r;

  // even bank: bytes at even addresses, low half of a word
  always_ff @(posedge clk) begin
    if (req.wr_en && !req.wr_addr[0]) begin
      even_mem[req.wr_addr[oamu_pkg::MEM_AW-1:1]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_lo_r <= even_mem[req.rd_row];
    end
  end

  // odd bank: high half of a word
  always_ff @(posedge clk) begin
    if (req.wr_en && req.wr_addr[0]) begin
      odd_mem[req.wr_addr[oamu_pkg::MEM_AW-1:1]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_hi_r <= odd_mem[req.rd_row];
    end
  end

  assign rd_lo = rd_lo_r;
  assign rd_hi = rd_hi_r;

endmodule
